@@ rtl/csi_pkg.sv @@
// ----------------------------------------------------------------------------
// csi_pkg
// Shared widths, codes and controller/datapath command types for the
// cluster silhouette index block.
// ----------------------------------------------------------------------------
package csi_pkg;

    // store geometry
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_BITS   = 16;

    // field widths
    localparam int PIDX_W     = 10;
    localparam int FIDX_W     = 3;
    localparam int LABEL_W    = 4;
    localparam int CADDR_W    = PIDX_W + FIDX_W;
    localparam int CNT_W      = 11;
    localparam int DIM_W      = 4;
    localparam int CLU_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // arithmetic widths
    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int ACC_W     = 36;
    localparam int ROOT_W    = ACC_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int SQ_CNT_W  = 5;
    localparam int DSUM_W    = 40;
    localparam int SIL_W     = 28;
    localparam int S_W       = 16;
    localparam int TOT_W     = 20;
    localparam int DIV_W     = 40;
    localparam int DVSR_W    = 18;
    localparam int DIV_CNT_W = 6;
    localparam int Q14_SHIFT = 14;
    localparam int Q14_ONE   = 16384;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd2;

    // datapath operations
    typedef enum logic [5:0] {
        OP_NOP, OP_CLEAR, OP_P_INIT, OP_CNT_RD, OP_CNT_UPD, OP_P_RD, OP_P_SKIP,
        OP_P_OWN, OP_LD_RD, OP_LD_WR, OP_Q_INIT, OP_Q_RD, OP_Q_LAB, OP_F_RD,
        OP_F_SUB, OP_F_MUL, OP_F_ACC, OP_SQ_INIT, OP_SQ_STEP, OP_Q_ADD,
        OP_A_DIV, OP_A_TAKE, OP_K_SKIP, OP_K_DIV, OP_K_TAKE, OP_S_ZERO,
        OP_S_DIV, OP_S_TAKE, OP_S_ADD, OP_FIN_INIT, OP_FK_DIV, OP_FK_TAKE,
        OP_FT_ZERO, OP_FT_DIV, OP_FT_TAKE, OP_OUT
    } dp_op_t;

    // cluster table index source
    typedef enum logic [1:0] {
        SEL_OWN, SEL_K, SEL_QLAB, SEL_LABEL
    } dp_sel_t;

    typedef struct packed {
        dp_op_t  op;
        dp_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic p_end;
        logic q_end;
        logic f_end;
        logic k_end;
        logic own_bad;
        logic k_skip;
        logic size_zero;
        logic sq_done;
        logic div_done;
        logic s_zero;
        logic used_zero;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/csi_if.sv @@
// ----------------------------------------------------------------------------
// csi interfaces
// Handshake channels for item requests, results and register writes.
// ----------------------------------------------------------------------------
interface csi_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [9:0]  point_index;
    logic [2:0]  feature_index;
    logic signed [15:0] coordinate;
    logic [3:0]  cluster_label;

    modport source (output valid, command, point_index, feature_index, coordinate,
                    cluster_label, input ready);
    modport sink   (input valid, command, point_index, feature_index, coordinate,
                    cluster_label, output ready);
endinterface

interface csi_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] silhouette;
    logic [4:0]  clusters_used;

    modport source (output valid, silhouette, clusters_used, input ready);
    modport sink   (input valid, silhouette, clusters_used, output ready);
endinterface

interface csi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/csi_ram.sv @@
// ----------------------------------------------------------------------------
// csi_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/csi_div.sv @@
// ----------------------------------------------------------------------------
// csi_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [csi_pkg::DIV_W-1:0]   dividend,
    input  logic [csi_pkg::DVSR_W-1:0]  divisor,
    output logic                        done,
    output logic [csi_pkg::DIV_W-1:0]   quotient
);
    import csi_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVSR_W:0]      rem_sh;
    logic                 fits;

    // one restoring step
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVSR_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign done     = !busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/csi_dpath.sv @@
// ----------------------------------------------------------------------------
// csi_dpath
// Datapath: point stores, configuration registers, distance and square root
// units, cluster tables, divider and result register.
// ----------------------------------------------------------------------------
module csi_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  csi_pkg::dp_cmd_t                 cmd,
    output csi_pkg::dp_status_t              status,
    input  logic                             req_fire,
    input  logic                             req_command,
    input  logic [csi_pkg::PIDX_W-1:0]       req_point_index,
    input  logic [csi_pkg::FIDX_W-1:0]       req_feature_index,
    input  logic signed [csi_pkg::COORD_BITS-1:0] req_coordinate,
    input  logic [csi_pkg::LABEL_W-1:0]      req_cluster_label,
    input  logic                             cfg_fire,
    input  logic [csi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csi_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic signed [csi_pkg::S_W-1:0]   silhouette,
    output logic [csi_pkg::CLU_W-1:0]        clusters_used
);
    import csi_pkg::*;

    // configuration
    logic [CNT_W-1:0] pc_reg;
    logic [DIM_W-1:0] dc_reg;
    logic [CLU_W-1:0] cc_reg;
    logic [CNT_W-1:0] np;
    logic [DIM_W-1:0] nd;
    logic [CLU_W-1:0] nc;

    // counters
    logic [CNT_W-1:0] p_reg, p_next, q_reg, q_next;
    logic [DIM_W-1:0] f_reg, f_next;
    logic [CLU_W-1:0] k_reg, k_next;

    // stores
    logic                  ld_we;
    logic [CADDR_W-1:0]    crd_raddr;
    logic [COORD_BITS-1:0] crd_rdata;
    logic [PIDX_W-1:0]     lab_raddr;
    logic [LABEL_W-1:0]    lab_rdata;

    // distance
    logic [LABEL_W-1:0]           own_reg, own_next, qlab_reg, qlab_next;
    logic signed [COORD_BITS-1:0] pvec_reg [MAX_DIMS];
    logic signed [COORD_BITS-1:0] pvec_next [MAX_DIMS];
    logic signed [COORD_BITS:0]   diff_reg, diff_next;
    logic [COORD_BITS:0]          diff_abs;
    logic [SQ_W-1:0]              sq_reg, sq_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;

    // square root
    logic [ACC_W-1:0]    sqn_reg, sqn_next;
    logic [REM_W-1:0]    sqrem_reg, sqrem_next, rem_sh, trial;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SQ_CNT_W-1:0] sqcnt_reg, sqcnt_next;

    // cluster tables
    logic [CNT_W-1:0]        size_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]        size_next [MAX_CLUSTERS];
    logic [DSUM_W-1:0]       dsum_reg [MAX_CLUSTERS];
    logic [DSUM_W-1:0]       dsum_next [MAX_CLUSTERS];
    logic signed [SIL_W-1:0] silsum_reg [MAX_CLUSTERS];
    logic signed [SIL_W-1:0] silsum_next [MAX_CLUSTERS];
    logic [IDX_W-1:0]        cidx;
    logic [CNT_W-1:0]        size_sel;
    logic [DSUM_W-1:0]       dsum_sel;
    logic signed [SIL_W-1:0] silsum_sel;

    // per point and final terms
    logic [ROOT_W-1:0]       a_reg, a_next, b_reg, b_next, den, ba_mag;
    logic                    found_reg, found_next;
    logic signed [ROOT_W:0]  ba_diff;
    logic signed [S_W-1:0]   s_reg, s_next, res_reg, res_next;
    logic signed [TOT_W-1:0] total_reg, total_next, q_tot, ft_val;
    logic [TOT_W-1:0]        tot_mag;
    logic [SIL_W-1:0]        sil_mag;
    logic [CLU_W-1:0]        used_reg, used_next;

    // divider
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quot;
    logic [DVSR_W-1:0] div_divisor;
    logic [S_W-1:0]    q_s;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic signed [S_W-1:0]   out_silh_reg, out_silh_next;
    logic [CLU_W-1:0]        out_used_reg, out_used_next;

    // register limits
    assign np = (pc_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pc_reg;
    assign nd = (dc_reg > DIM_W'(MAX_DIMS)) ? DIM_W'(MAX_DIMS) : dc_reg;
    assign nc = (cc_reg > CLU_W'(MAX_CLUSTERS)) ? CLU_W'(MAX_CLUSTERS) : cc_reg;

    // point stores
    assign ld_we     = req_fire && (req_command == CMD_LOAD);
    assign crd_raddr = (cmd.op == OP_F_RD) ? {q_reg[PIDX_W-1:0], f_reg[FIDX_W-1:0]}
                                           : {p_reg[PIDX_W-1:0], f_reg[FIDX_W-1:0]};
    assign lab_raddr = (cmd.op == OP_Q_RD) ? q_reg[PIDX_W-1:0] : p_reg[PIDX_W-1:0];

    csi_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_POINTS * MAX_DIMS)
    ) u_coord_ram (
        .clk   (clk),
        .we    (ld_we),
        .waddr ({req_point_index, req_feature_index}),
        .wdata (req_coordinate),
        .raddr (crd_raddr),
        .rdata (crd_rdata)
    );

    csi_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_POINTS)
    ) u_label_ram (
        .clk   (clk),
        .we    (ld_we),
        .waddr (req_point_index),
        .wdata (req_cluster_label),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    // cluster table read port
    always_comb
    begin
        case (cmd.sel)
            SEL_OWN:   cidx = own_reg;
            SEL_K:     cidx = k_reg[IDX_W-1:0];
            SEL_QLAB:  cidx = qlab_reg;
            SEL_LABEL: cidx = lab_rdata;
            default:   cidx = own_reg;
        endcase
    end

    assign size_sel   = size_reg[cidx];
    assign dsum_sel   = dsum_reg[cidx];
    assign silsum_sel = silsum_reg[cidx];

    // silhouette term operands
    assign den     = (a_reg > b_reg) ? a_reg : b_reg;
    assign ba_diff = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
    assign ba_mag  = ba_diff[ROOT_W] ? ROOT_W'(-ba_diff) : ba_diff[ROOT_W-1:0];
    assign sil_mag = silsum_sel[SIL_W-1] ? SIL_W'(-silsum_sel) : SIL_W'(silsum_sel);
    assign tot_mag = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(dsum_sel);
        div_divisor  = DVSR_W'(size_sel);
        case (cmd.op)
            OP_A_DIV, OP_K_DIV:
            begin
                div_start = 1'b1;
            end
            OP_S_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({ba_mag, Q14_SHIFT'(0)});
                div_divisor  = den;
            end
            OP_FK_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(sil_mag);
            end
            OP_FT_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(tot_mag);
                div_divisor  = DVSR_W'(used_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    csi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign q_s    = div_quot[S_W-1:0];
    assign q_tot  = $signed(TOT_W'(q_s));
    assign ft_val = total_reg[TOT_W-1] ? -q_tot : q_tot;

    // square root step
    assign rem_sh   = {sqrem_reg[REM_W-3:0], sqn_reg[ACC_W-1 -: 2]};
    assign trial    = REM_W'({root_reg, 2'b01});
    assign diff_abs = diff_reg[COORD_BITS] ? (COORD_BITS+1)'(-diff_reg)
                                           : (COORD_BITS+1)'(diff_reg);

    // datapath next state
    always_comb
    begin
        p_next         = p_reg;
        q_next         = q_reg;
        f_next         = f_reg;
        k_next         = k_reg;
        own_next       = own_reg;
        qlab_next      = qlab_reg;
        pvec_next      = pvec_reg;
        diff_next      = diff_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        sqn_next       = sqn_reg;
        sqrem_next     = sqrem_reg;
        root_next      = root_reg;
        sqcnt_next     = sqcnt_reg;
        size_next      = size_reg;
        dsum_next      = dsum_reg;
        silsum_next    = silsum_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        found_next     = found_reg;
        s_next         = s_reg;
        res_next       = res_reg;
        total_next     = total_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_silh_next  = out_silh_reg;
        out_used_next  = out_used_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                for (int i = 0; i < MAX_CLUSTERS; i++)
                begin
                    size_next[i]   = '0;
                    silsum_next[i] = '0;
                end
                p_next = '0;
            end
            OP_P_INIT:
            begin
                p_next = '0;
            end
            OP_CNT_UPD:
            begin
                if ({1'b0, lab_rdata} < nc)
                begin
                    size_next[cidx] = size_sel + 1'b1;
                end
                p_next = p_reg + 1'b1;
            end
            OP_P_SKIP:
            begin
                p_next = p_reg + 1'b1;
            end
            OP_P_OWN:
            begin
                own_next = lab_rdata;
                for (int i = 0; i < MAX_CLUSTERS; i++)
                begin
                    dsum_next[i] = '0;
                end
                f_next = '0;
            end
            OP_LD_WR:
            begin
                pvec_next[f_reg[FIDX_W-1:0]] = $signed(crd_rdata);
                f_next = f_reg + 1'b1;
            end
            OP_Q_INIT:
            begin
                q_next = '0;
            end
            OP_Q_RD:
            begin
                acc_next = '0;
                f_next   = '0;
            end
            OP_Q_LAB:
            begin
                qlab_next = lab_rdata;
            end
            OP_F_SUB:
            begin
                diff_next = $signed({crd_rdata[COORD_BITS-1], crd_rdata})
                          - $signed({pvec_reg[f_reg[FIDX_W-1:0]][COORD_BITS-1],
                                     pvec_reg[f_reg[FIDX_W-1:0]]});
            end
            OP_F_MUL:
            begin
                sq_next = diff_abs[COORD_BITS-1:0] * diff_abs[COORD_BITS-1:0];
            end
            OP_F_ACC:
            begin
                acc_next = acc_reg + ACC_W'(sq_reg);
                f_next   = f_reg + 1'b1;
            end
            OP_SQ_INIT:
            begin
                sqn_next   = acc_reg;
                sqrem_next = '0;
                root_next  = '0;
                sqcnt_next = SQ_CNT_W'(ROOT_W);
            end
            OP_SQ_STEP:
            begin
                if (rem_sh >= trial)
                begin
                    sqrem_next = rem_sh - trial;
                    root_next  = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sqrem_next = rem_sh;
                    root_next  = {root_reg[ROOT_W-2:0], 1'b0};
                end
                sqn_next   = {sqn_reg[ACC_W-3:0], 2'b00};
                sqcnt_next = sqcnt_reg - 1'b1;
            end
            OP_Q_ADD:
            begin
                if ({1'b0, qlab_reg} < nc)
                begin
                    dsum_next[cidx] = dsum_sel + DSUM_W'(root_reg);
                end
                q_next = q_reg + 1'b1;
            end
            OP_A_TAKE:
            begin
                a_next     = div_quot[ROOT_W-1:0];
                b_next     = '0;
                found_next = 1'b0;
                k_next     = '0;
            end
            OP_K_SKIP:
            begin
                k_next = k_reg + 1'b1;
            end
            OP_K_TAKE:
            begin
                if (!found_reg || (div_quot[ROOT_W-1:0] < b_reg))
                begin
                    b_next = div_quot[ROOT_W-1:0];
                end
                found_next = 1'b1;
                k_next     = k_reg + 1'b1;
            end
            OP_S_ZERO:
            begin
                s_next = '0;
            end
            OP_S_TAKE:
            begin
                s_next = ba_diff[ROOT_W] ? -$signed(q_s) : $signed(q_s);
            end
            OP_S_ADD:
            begin
                silsum_next[cidx] = silsum_sel + SIL_W'(s_reg);
                p_next = p_reg + 1'b1;
            end
            OP_FIN_INIT:
            begin
                total_next = '0;
                used_next  = '0;
                k_next     = '0;
            end
            OP_FK_TAKE:
            begin
                total_next = silsum_sel[SIL_W-1] ? total_reg - q_tot : total_reg + q_tot;
                used_next  = used_reg + 1'b1;
                k_next     = k_reg + 1'b1;
            end
            OP_FT_ZERO:
            begin
                res_next = '0;
            end
            OP_FT_TAKE:
            begin
                if (ft_val > TOT_W'(Q14_ONE))
                begin
                    res_next = S_W'(Q14_ONE);
                end
                else if (ft_val < -TOT_W'(Q14_ONE))
                begin
                    res_next = -S_W'(Q14_ONE);
                end
                else
                begin
                    res_next = ft_val[S_W-1:0];
                end
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_silh_next  = res_reg;
                out_used_next  = used_reg;
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= CNT_W'(1);
            dc_reg        <= DIM_W'(1);
            cc_reg        <= CLU_W'(2);
            p_reg         <= '0;
            q_reg         <= '0;
            f_reg         <= '0;
            k_reg         <= '0;
            sqcnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire && (cfg_index == CFG_POINT_COUNT))
            begin
                pc_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_fire && (cfg_index == CFG_DIM_COUNT))
            begin
                dc_reg <= cfg_data[DIM_W-1:0];
            end
            if (cfg_fire && (cfg_index == CFG_CLUSTER_COUNT))
            begin
                cc_reg <= cfg_data[CLU_W-1:0];
            end
            p_reg         <= p_next;
            q_reg         <= q_next;
            f_reg         <= f_next;
            k_reg         <= k_next;
            sqcnt_reg     <= sqcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        own_reg      <= own_next;
        qlab_reg     <= qlab_next;
        pvec_reg     <= pvec_next;
        diff_reg     <= diff_next;
        sq_reg       <= sq_next;
        acc_reg      <= acc_next;
        sqn_reg      <= sqn_next;
        sqrem_reg    <= sqrem_next;
        root_reg     <= root_next;
        size_reg     <= size_next;
        dsum_reg     <= dsum_next;
        silsum_reg   <= silsum_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        found_reg    <= found_next;
        s_reg        <= s_next;
        res_reg      <= res_next;
        total_reg    <= total_next;
        used_reg     <= used_next;
        out_silh_reg <= out_silh_next;
        out_used_reg <= out_used_next;
    end

    // status to controller
    assign status.p_end     = (p_reg == np);
    assign status.q_end     = (q_reg == np);
    assign status.f_end     = (f_reg == nd);
    assign status.k_end     = (k_reg == nc);
    assign status.own_bad   = ({1'b0, lab_rdata} >= nc);
    assign status.size_zero = (size_sel == '0);
    assign status.k_skip    = (k_reg[IDX_W-1:0] == own_reg) || (size_sel == '0);
    assign status.sq_done   = (sqcnt_reg == '0);
    assign status.div_done  = div_done;
    assign status.s_zero    = !found_reg || (den == '0);
    assign status.used_zero = (used_reg == '0);
    assign status.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid     = out_valid_reg;
    assign silhouette    = out_silh_reg;
    assign clusters_used = out_used_reg;

endmodule

@@ rtl/csi_ctrl.sv @@
// ----------------------------------------------------------------------------
// csi_ctrl
// Controller state machine sequencing counting, distance, division and
// averaging passes of the datapath.
// ----------------------------------------------------------------------------
module csi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_fire,
    input  logic                req_command,
    input  csi_pkg::dp_status_t status,
    output csi_pkg::dp_cmd_t    cmd,
    output logic                req_ready
);
    import csi_pkg::*;

    localparam int ST_W = 28;

    typedef enum logic [ST_W-1:0] {
        ST_IDLE     = ST_W'(1) << 0,
        ST_CLEAR    = ST_W'(1) << 1,
        ST_CNT_RD   = ST_W'(1) << 2,
        ST_CNT_UPD  = ST_W'(1) << 3,
        ST_P_RD     = ST_W'(1) << 4,
        ST_P_OWN    = ST_W'(1) << 5,
        ST_LD_RD    = ST_W'(1) << 6,
        ST_LD_WR    = ST_W'(1) << 7,
        ST_Q_RD     = ST_W'(1) << 8,
        ST_Q_LAB    = ST_W'(1) << 9,
        ST_F_RD     = ST_W'(1) << 10,
        ST_F_SUB    = ST_W'(1) << 11,
        ST_F_MUL    = ST_W'(1) << 12,
        ST_F_ACC    = ST_W'(1) << 13,
        ST_SQ_RUN   = ST_W'(1) << 14,
        ST_A_DIV    = ST_W'(1) << 15,
        ST_A_WAIT   = ST_W'(1) << 16,
        ST_K_LOOP   = ST_W'(1) << 17,
        ST_K_WAIT   = ST_W'(1) << 18,
        ST_S_CALC   = ST_W'(1) << 19,
        ST_S_WAIT   = ST_W'(1) << 20,
        ST_S_ADD    = ST_W'(1) << 21,
        ST_FIN_INIT = ST_W'(1) << 22,
        ST_FK_LOOP  = ST_W'(1) << 23,
        ST_FK_WAIT  = ST_W'(1) << 24,
        ST_FT_CALC  = ST_W'(1) << 25,
        ST_FT_WAIT  = ST_W'(1) << 26,
        ST_OUT      = ST_W'(1) << 27
    } state_t;

    state_t state_reg, state_next;

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        cmd.sel    = SEL_OWN;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req_command == CMD_COMPUTE))
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = ST_CNT_RD;
            end
            ST_CNT_RD:
            begin
                if (status.p_end)
                begin
                    cmd.op     = OP_P_INIT;
                    state_next = ST_P_RD;
                end
                else
                begin
                    cmd.op     = OP_CNT_RD;
                    state_next = ST_CNT_UPD;
                end
            end
            ST_CNT_UPD:
            begin
                cmd.op     = OP_CNT_UPD;
                cmd.sel    = SEL_LABEL;
                state_next = ST_CNT_RD;
            end
            ST_P_RD:
            begin
                if (status.p_end)
                begin
                    state_next = ST_FIN_INIT;
                end
                else
                begin
                    cmd.op     = OP_P_RD;
                    state_next = ST_P_OWN;
                end
            end
            ST_P_OWN:
            begin
                if (status.own_bad)
                begin
                    cmd.op     = OP_P_SKIP;
                    state_next = ST_P_RD;
                end
                else
                begin
                    cmd.op     = OP_P_OWN;
                    state_next = ST_LD_RD;
                end
            end
            ST_LD_RD:
            begin
                if (status.f_end)
                begin
                    cmd.op     = OP_Q_INIT;
                    state_next = ST_Q_RD;
                end
                else
                begin
                    cmd.op     = OP_LD_RD;
                    state_next = ST_LD_WR;
                end
            end
            ST_LD_WR:
            begin
                cmd.op     = OP_LD_WR;
                state_next = ST_LD_RD;
            end
            ST_Q_RD:
            begin
                if (status.q_end)
                begin
                    state_next = ST_A_DIV;
                end
                else
                begin
                    cmd.op     = OP_Q_RD;
                    state_next = ST_Q_LAB;
                end
            end
            ST_Q_LAB:
            begin
                cmd.op     = OP_Q_LAB;
                state_next = ST_F_RD;
            end
            ST_F_RD:
            begin
                if (status.f_end)
                begin
                    cmd.op     = OP_SQ_INIT;
                    state_next = ST_SQ_RUN;
                end
                else
                begin
                    cmd.op     = OP_F_RD;
                    state_next = ST_F_SUB;
                end
            end
            ST_F_SUB:
            begin
                cmd.op     = OP_F_SUB;
                state_next = ST_F_MUL;
            end
            ST_F_MUL:
            begin
                cmd.op     = OP_F_MUL;
                state_next = ST_F_ACC;
            end
            ST_F_ACC:
            begin
                cmd.op     = OP_F_ACC;
                state_next = ST_F_RD;
            end
            ST_SQ_RUN:
            begin
                cmd.sel = SEL_QLAB;
                if (status.sq_done)
                begin
                    cmd.op     = OP_Q_ADD;
                    state_next = ST_Q_RD;
                end
                else
                begin
                    cmd.op = OP_SQ_STEP;
                end
            end
            ST_A_DIV:
            begin
                cmd.op     = OP_A_DIV;
                state_next = ST_A_WAIT;
            end
            ST_A_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_A_TAKE;
                    state_next = ST_K_LOOP;
                end
            end
            ST_K_LOOP:
            begin
                cmd.sel = SEL_K;
                if (status.k_end)
                begin
                    state_next = ST_S_CALC;
                end
                else if (status.k_skip)
                begin
                    cmd.op = OP_K_SKIP;
                end
                else
                begin
                    cmd.op     = OP_K_DIV;
                    state_next = ST_K_WAIT;
                end
            end
            ST_K_WAIT:
            begin
                cmd.sel = SEL_K;
                if (status.div_done)
                begin
                    cmd.op     = OP_K_TAKE;
                    state_next = ST_K_LOOP;
                end
            end
            ST_S_CALC:
            begin
                if (status.s_zero)
                begin
                    cmd.op     = OP_S_ZERO;
                    state_next = ST_S_ADD;
                end
                else
                begin
                    cmd.op     = OP_S_DIV;
                    state_next = ST_S_WAIT;
                end
            end
            ST_S_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_S_TAKE;
                    state_next = ST_S_ADD;
                end
            end
            ST_S_ADD:
            begin
                cmd.op     = OP_S_ADD;
                state_next = ST_P_RD;
            end
            ST_FIN_INIT:
            begin
                cmd.op     = OP_FIN_INIT;
                state_next = ST_FK_LOOP;
            end
            ST_FK_LOOP:
            begin
                cmd.sel = SEL_K;
                if (status.k_end)
                begin
                    state_next = ST_FT_CALC;
                end
                else if (status.size_zero)
                begin
                    cmd.op = OP_K_SKIP;
                end
                else
                begin
                    cmd.op     = OP_FK_DIV;
                    state_next = ST_FK_WAIT;
                end
            end
            ST_FK_WAIT:
            begin
                cmd.sel = SEL_K;
                if (status.div_done)
                begin
                    cmd.op     = OP_FK_TAKE;
                    state_next = ST_FK_LOOP;
                end
            end
            ST_FT_CALC:
            begin
                if (status.used_zero)
                begin
                    cmd.op     = OP_FT_ZERO;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_FT_DIV;
                    state_next = ST_FT_WAIT;
                end
            end
            ST_FT_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_FT_TAKE;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/cluster_silhouette_index.sv @@
// ----------------------------------------------------------------------------
// cluster_silhouette_index
// Fixed-point silhouette coefficient over a loaded, labelled point set.
// ----------------------------------------------------------------------------
// Load transactions may follow back to back; each writes one Q8.8
// coordinate and the point label into on-chip RAM. A compute transaction
// runs alone; its run time is set by the single coordinate RAM read port
// (one feature per step), the bit-serial square root (18 steps per pair)
// and the shared one-bit-per-cycle divider (40 steps per division, plus
// an issue and a take step). The result register holds the last result
// until taken while new loads are accepted. Register writes may happen at
// any time the block is idle.
module cluster_silhouette_index (
    input  logic      clk,
    input  logic      rst_n,
    csi_req_if.sink   req,
    csi_rsp_if.source rsp,
    csi_cfg_if.sink   cfg
);
    import csi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       req_ready;
    logic       req_fire;
    logic       cfg_fire;

    // handshakes
    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req_ready;
    assign cfg_fire  = cfg.valid;

    csi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_fire    (req_fire),
        .req_command (req.command),
        .status      (status),
        .cmd         (cmd),
        .req_ready   (req_ready)
    );

    csi_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .req_fire          (req_fire),
        .req_command       (req.command),
        .req_point_index   (req.point_index),
        .req_feature_index (req.feature_index),
        .req_coordinate    (req.coordinate),
        .req_cluster_label (req.cluster_label),
        .cfg_fire          (cfg_fire),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .silhouette        (rsp.silhouette),
        .clusters_used     (rsp.clusters_used)
    );

endmodule
